FILE: hdl/adaptive_lawnmower_survey_step_defines.svh
// assertion macros for the survey step block
`ifndef ADAPTIVE_LAWNMOWER_SURVEY_STEP_DEFINES_SVH
`define ADAPTIVE_LAWNMOWER_SURVEY_STEP_DEFINES_SVH

// property a implies property b in the same cycle
`define ALS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// property a implies property b in the next cycle
`define ALS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

FILE: hdl/als_pkg.sv
// types and constants shared by the survey step modules
package als_pkg;

	typedef struct packed {
		logic [15:0] plume_level;
		logic        section_end;
	} als_in_t;

	typedef struct packed {
		logic [9:0]         track_index;
		logic [9:0]         section_index;
		logic signed [39:0] offset_x;
		logic signed [39:0] offset_y;
		logic               survey_done;
		logic               count_overflow;
	} als_out_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CONT_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SECT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_THR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACROSS_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACROSS_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALONG_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALONG_Y    = 3'd6;

	typedef struct packed {
		logic [15:0]        cont_thr;
		logic [7:0]         min_sect;
		logic [4:0]         run_thr;
		logic signed [23:0] across_x;
		logic signed [23:0] across_y;
		logic signed [23:0] along_x;
		logic signed [23:0] along_y;
	} als_cfg_t;

	// controller commands to the datapath
	typedef struct packed {
		logic sample;      // accumulate one sample
		logic div_start;   // start the average divide
		logic div_store;   // push quotient into history, update run state
		logic chk_start;   // start the history check
		logic decide;      // take turn decision and update counters
		logic mul_start;   // start offset products
		logic out_load;    // load the result register
		logic clr_section; // clear per-section accumulation
	} als_cmd_t;

	typedef struct packed {
		logic last;      // current input sample ends the section
		logic same_trk;  // section is evaluated
		logic div_busy;
		logic chk_busy;
		logic mul_busy;
	} als_sts_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV    = 7'b0000010,
		ST_STORE  = 7'b0000100,
		ST_CHECK  = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_MUL    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} als_state_t;

endpackage

FILE: hdl/als_ctrl.sv
// sequencer for one survey sample and the section-end update
module als_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           in_last,
	input  logic           out_free,
	input  als_pkg::als_sts_t sts,
	output als_pkg::als_cmd_t cmd,
	output logic           in_ready
);
	import als_pkg::*;

	als_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.sample = 1'b1;
					if (in_last) begin
						if (sts.same_trk) begin
							cmd.div_start = 1'b1;
							state_d = ST_DIV;
						end else begin
							state_d = ST_CHECK;
						end
					end
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.div_store = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.chk_start = 1'b1;
				cmd.clr_section = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!sts.chk_busy) begin
					cmd.decide = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.mul_busy && out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/als_dp.sv
// survey datapath: accumulator, divider, history, counters and offset products
module als_dp #(
	parameter int unsigned MAX_SAMPLES   = 1024,
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned COUNT_LIMIT   = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  als_pkg::als_cmd_t cmd,
	input  als_pkg::als_in_t  in_item,
	input  als_pkg::als_cfg_t cfg,
	output als_pkg::als_sts_t sts,
	output als_pkg::als_out_t res
);
	import als_pkg::*;

	localparam int unsigned SC_W  = $clog2(MAX_SAMPLES + 2);
	localparam int unsigned SUM_W = 16 + $clog2(MAX_SAMPLES + 1);
	localparam int unsigned NUM_W = SUM_W + 8;
	localparam int unsigned DIV_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned HI_W  = $clog2(HISTORY_DEPTH);
	localparam int unsigned HF_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
	localparam int unsigned NC_W  = $clog2(NUM_W + 1);
	localparam logic [SC_W-1:0]  MAXS  = SC_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] CLIM  = CNT_W'(COUNT_LIMIT);
	localparam logic [HF_W-1:0]  HDEP  = HF_W'(HISTORY_DEPTH);

	// section accumulation
	logic [SUM_W-1:0] sum_q;
	logic [SC_W-1:0]  scnt_q;
	logic             over_q;

	// tracking state
	logic [CNT_W-1:0] track_q, sect_q;
	logic             same_q, clean_q, done_q, ovf_q;
	logic [7:0]       run_q, compl_q;
	logic [HF_W-1:0]  fill_q;
	logic [23:0]      hist_q [HISTORY_DEPTH];

	// divider
	logic [NUM_W-1:0] dnum_q;
	logic [DIV_W:0]   drem_q;
	logic [DIV_W-1:0] dden_q;
	logic [NC_W-1:0]  dcnt_q;

	// history check
	logic [HI_W:0]    ccnt_q;
	logic [HF_W-1:0]  cn_q;
	logic             cbad_q;

	// offset products: serial shift-add over the counter bits
	logic [CNT_W-1:0] mt_q, ms_q;
	logic [$clog2(CNT_W+1)-1:0] mcnt_q;
	logic signed [39:0] ax_q, ay_q;

	logic [SUM_W-1:0] sum_nx;
	logic [SC_W-1:0]  scnt_nx;
	logic [SC_W-1:0]  div_sel;
	logic [DIV_W:0]   rem_sh;
	logic             ge;

	// sum and count including the sample of this transfer
	always_comb begin
		if (scnt_q < MAXS) begin
			sum_nx = sum_q + SUM_W'(in_item.plume_level);
			scnt_nx = scnt_q + 1'b1;
		end else begin
			sum_nx = sum_q;
			scnt_nx = MAXS + 1'b1;
		end
		div_sel = (scnt_nx > MAXS) ? MAXS : scnt_nx;
		if (div_sel == '0) div_sel = SC_W'(1);
		rem_sh = {drem_q[DIV_W-1:0], dnum_q[NUM_W-1]};
		ge = rem_sh >= {1'b0, dden_q};
	end

	logic turn, odd_trk, allowed;
	always_comb begin
		odd_trk = track_q[0];
		allowed = (compl_q >= cfg.min_sect) && (run_q >= {3'd0, cfg.run_thr}) && !cbad_q;
		turn = allowed || (odd_trk && sect_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0; scnt_q <= '0; over_q <= 1'b0;
			track_q <= '0; sect_q <= '0; same_q <= 1'b0; clean_q <= 1'b1;
			done_q <= 1'b0; ovf_q <= 1'b0; run_q <= '0; compl_q <= '0; fill_q <= '0;
			dcnt_q <= '0; ccnt_q <= '0; mcnt_q <= '0; cbad_q <= 1'b0; cn_q <= '0;
			dnum_q <= '0; drem_q <= '0; dden_q <= '0;
			mt_q <= '0; ms_q <= '0; ax_q <= '0; ay_q <= '0;
		end else begin
			if (cmd.sample) begin
				if (in_item.plume_level >= cfg.cont_thr) over_q <= 1'b1;
				sum_q <= sum_nx;
				scnt_q <= scnt_nx;
				if (in_item.section_end) ovf_q <= (scnt_q >= MAXS);
			end
			if (cmd.div_start) begin
				dcnt_q <= NC_W'(NUM_W);
				dnum_q <= {sum_nx, 8'd0};
				drem_q <= '0;
				dden_q <= DIV_W'(div_sel);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 1'b1;
				dnum_q <= {dnum_q[NUM_W-2:0], ge};
				drem_q <= ge ? rem_sh - {1'b0, dden_q} : rem_sh;
			end
			if (cmd.div_store) begin
				if (fill_q < HDEP) fill_q <= fill_q + 1'b1;
				if (!over_q) begin
					if (run_q != 8'hFF) run_q <= run_q + 1'b1;
				end else begin
					clean_q <= 1'b0;
					run_q <= '0;
				end
			end
			if (cmd.clr_section) begin
				sum_q <= '0; scnt_q <= '0; over_q <= 1'b0; same_q <= 1'b1;
			end
			if (cmd.chk_start) begin
				cn_q <= (8'(cfg.run_thr) < 8'(fill_q)) ? HF_W'(cfg.run_thr) : fill_q;
				ccnt_q <= '0;
				cbad_q <= 1'b0;
			end else if (ccnt_q[HI_W-1:0] != '1 && HF_W'(ccnt_q) + 2'd2 <= cn_q && !cbad_q
				&& !ccnt_q[HI_W]) begin
				if (hist_q[ccnt_q[HI_W-1:0] + 1'b1] < hist_q[ccnt_q[HI_W-1:0]]) cbad_q <= 1'b1;
				ccnt_q <= ccnt_q + 1'b1;
			end else begin
				ccnt_q[HI_W] <= 1'b1;
			end
			if (cmd.decide) begin
				if (turn) begin
					if (track_q < CLIM) track_q <= track_q + 1'b1; else ovf_q <= 1'b1;
					same_q <= 1'b0;
					if (!clean_q) begin
						run_q <= '0; clean_q <= 1'b1; compl_q <= '0; fill_q <= '0;
					end else begin
						done_q <= 1'b1;
					end
				end else begin
					if (!odd_trk) begin
						if (sect_q < CLIM) sect_q <= sect_q + 1'b1; else ovf_q <= 1'b1;
					end else if (sect_q != '0) begin
						sect_q <= sect_q - 1'b1;
					end
					if (compl_q != 8'hFF) compl_q <= compl_q + 1'b1;
				end
			end
			if (cmd.mul_start) begin
				mt_q <= track_q; ms_q <= sect_q;
				mcnt_q <= ($clog2(CNT_W+1))'(CNT_W);
				ax_q <= '0; ay_q <= '0;
			end else if (mcnt_q != '0) begin
				mcnt_q <= mcnt_q - 1'b1;
				ax_q <= (ax_q <<< 1) + (mt_q[CNT_W-1] ? 40'(cfg.across_x) : '0)
					+ (ms_q[CNT_W-1] ? 40'(cfg.along_x) : '0);
				ay_q <= (ay_q <<< 1) + (mt_q[CNT_W-1] ? 40'(cfg.across_y) : '0)
					+ (ms_q[CNT_W-1] ? 40'(cfg.along_y) : '0);
				mt_q <= mt_q << 1;
				ms_q <= ms_q << 1;
			end
		end
	end

	// history shift register, newest at entry 0
	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			hist_q[0] <= dnum_q[23:0];
			for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	always_comb begin
		sts.last = in_item.section_end;
		sts.same_trk = same_q;
		sts.div_busy = (dcnt_q != '0);
		sts.chk_busy = cmd.chk_start || !ccnt_q[HI_W];
		sts.mul_busy = (mcnt_q != '0);
		res.track_index = 10'(track_q);
		res.section_index = 10'(sect_q);
		res.offset_x = ax_q;
		res.offset_y = ay_q;
		res.survey_done = done_q;
		res.count_overflow = ovf_q;
	end

endmodule

FILE: hdl/adaptive_lawnmower_survey_step.sv
// top level of the adaptive lawnmower survey step block
// Usage:
// - input channel in_valid/in_stall carries one plume sample per transfer in
//   in_data; section_end marks the last sample of a section.
// - a sample that does not end a section is taken while the block stays idle: the
//   block is ready again in the next cycle.
// - a section end runs the update sequence: restoring divide of the section
//   average (one quotient bit a cycle; skipped for the first section of a track),
//   a history check (one pair a cycle), the turn decision, and serial offset
//   products (one counter bit a cycle).
// - out_valid/out_stall: one result per section in out_data, held in an
//   output register until transferred; a stall holds the result and the block
//   waits before loading the next one.
// - cfg_valid/cfg_ready writes register cfg_index with cfg_data; write only
//   while idle. cfg_ready is always high.
// - arst_n clears all counters and flags (clean_q is set) and restores register defaults.
module adaptive_lawnmower_survey_step #(
	parameter int unsigned MAX_SAMPLES   = 1024,
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned COUNT_LIMIT   = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  als_pkg::als_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output als_pkg::als_out_t            out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [als_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]                  cfg_data
);
	import als_pkg::*;
	`include "adaptive_lawnmower_survey_step_defines.svh"

	als_cfg_t cfg_q;
	als_cmd_t cmd;
	als_sts_t sts;
	als_out_t res;
	logic in_ready, in_fire, out_free;

	assign cfg_ready = 1'b1;
	assign in_stall = !in_ready;
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cont_thr <= 16'd32768; cfg_q.min_sect <= 8'd4; cfg_q.run_thr <= 5'd3;
			cfg_q.across_x <= 24'sd256; cfg_q.across_y <= '0;
			cfg_q.along_x <= '0; cfg_q.along_y <= 24'sd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CONT_THR: cfg_q.cont_thr <= cfg_data[15:0];
				REG_MIN_SECT: cfg_q.min_sect <= cfg_data[7:0];
				REG_RUN_THR:  cfg_q.run_thr <= cfg_data[4:0];
				REG_ACROSS_X: cfg_q.across_x <= cfg_data;
				REG_ACROSS_Y: cfg_q.across_y <= cfg_data;
				REG_ALONG_X:  cfg_q.along_x <= cfg_data;
				REG_ALONG_Y:  cfg_q.along_y <= cfg_data;
				default: ;
			endcase
		end
	end

	als_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(in_data.section_end),
		.out_free(out_free), .sts(sts), .cmd(cmd), .in_ready(in_ready)
	);

	als_dp #(
		.MAX_SAMPLES(MAX_SAMPLES), .HISTORY_DEPTH(HISTORY_DEPTH), .COUNT_LIMIT(COUNT_LIMIT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data), .cfg(cfg_q),
		.sts(sts), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_data <= res;
	end

	`ALS_ASSERT_IMPLIES(a_load_free, clk, arst_n, cmd.out_load, out_free)
	`ALS_ASSERT_IMPLIES(a_sample_ready, clk, arst_n, cmd.sample, in_ready)
	`ALS_ASSERT_NEXT(a_done_sticky, clk, arst_n, res.survey_done, res.survey_done)

endmodule
